// ===== src/psg_nls_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_nls_pkg: shared types and constants
// Command modes, chip write codes, melody table and write batch type for the
// note-length sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_nls_pkg;

    // Melody length, counted modulo this value
    localparam int SONG_STEPS = 16;
    localparam int STEP_W     = (SONG_STEPS > 2) ? $clog2(SONG_STEPS) : 1;

    // Chip layout
    localparam int NUM_CH     = 4;
    localparam int MAX_WRITES = 6;
    localparam int CNT_W      = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_LEVEL = 1'd1;
    localparam logic [7:0] NOTE_PERIOD_RST = 8'd9;
    localparam logic [3:0] MUSIC_LEVEL_RST = 4'd5;

    // Command modes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_TONE    = 3'd1;
    localparam logic [2:0] MODE_NOISE   = 3'd2;
    localparam logic [2:0] MODE_MUSIC   = 3'd3;
    localparam logic [2:0] MODE_ALL_OFF = 3'd4;

    // Chip write kinds
    localparam logic [1:0] KIND_FREQ  = 2'd0;
    localparam logic [1:0] KIND_ATTEN = 2'd1;
    localparam logic [1:0] KIND_NOISE = 2'd2;

    localparam logic [15:0] ATTEN_LOUD   = 16'd0;
    localparam logic [15:0] ATTEN_SILENT = 16'd15;
    localparam logic [15:0] NOISE_WHITE  = 16'd0;
    localparam logic [1:0]  MELODY_CH    = 2'd2;
    localparam logic [1:0]  NOISE_CH     = 2'd3;
    localparam logic [1:0]  LAST_TONE_CH = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [15:0] value;
    } write_t;

    // All writes caused by one command
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        write_t [MAX_WRITES-1:0]     writes;
    } batch_t;

    // Fixed background melody; zero entries are rests
    function automatic logic [15:0] melody_note(input logic [3:0] idx);
        logic [15:0] note;
        begin
            case (idx)
                4'd0:    note = 16'd262;
                4'd1:    note = 16'd330;
                4'd2:    note = 16'd392;
                4'd3:    note = 16'd523;
                4'd4:    note = 16'd392;
                4'd5:    note = 16'd330;
                4'd6:    note = 16'd262;
                4'd7:    note = 16'd0;
                4'd8:    note = 16'd220;
                4'd9:    note = 16'd262;
                4'd10:   note = 16'd330;
                4'd11:   note = 16'd440;
                4'd12:   note = 16'd330;
                4'd13:   note = 16'd262;
                4'd14:   note = 16'd220;
                default: note = 16'd0;
            endcase
            return note;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/psg_nls_if.sv =====
// ----------------------------------------------------------------------------
// psg_nls_if: channel interfaces
// Command channel and chip write channel, each valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface psg_nls_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [1:0]  channel;
    logic [15:0] tone_freq;
    logic [7:0]  note_len;
    logic        music_on;

    modport source (output valid, mode, channel, tone_freq, note_len, music_on,
                    input ready);
    modport sink   (input valid, mode, channel, tone_freq, note_len, music_on,
                    output ready);
endinterface

interface psg_nls_wr_if;
    logic        valid;
    logic        ready;
    logic [1:0]  write_kind;
    logic [1:0]  write_channel;
    logic [15:0] write_value;
    logic        last;

    modport source (output valid, write_kind, write_channel, write_value, last,
                    input ready);
    modport sink   (input valid, write_kind, write_channel, write_value, last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/psg_nls_engine.sv =====
// ----------------------------------------------------------------------------
// psg_nls_engine: command register, sequencer state and write decode
// Holds one command, and when the serializer can take a batch, updates the
// countdowns and melody state and hands over the list of chip writes.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_nls_engine (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    psg_nls_cmd_if.sink                               cmd,
    input  wire logic                                 cfg_we,
    input  wire logic [psg_nls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [psg_nls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                                 load_ok,
    output logic                                      batch_valid,
    output psg_nls_pkg::batch_t                       batch
);

    // Held command
    logic        hold_valid_reg;
    logic [2:0]  mode_reg;
    logic [1:0]  channel_reg;
    logic [15:0] freq_reg;
    logic [7:0]  len_reg;
    logic        on_reg;

    // Sequencer state
    logic [psg_nls_pkg::NUM_CH-1:0][7:0] frames_reg, frames_next;
    logic                                 enabled_reg, enabled_next;
    logic [psg_nls_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [7:0]                           timer_reg, timer_next;
    logic [7:0]                           period_reg;
    logic [3:0]                           level_reg;

    logic advance;
    logic cmd_fire;

    assign advance     = hold_valid_reg && load_ok;
    assign cmd.ready   = !hold_valid_reg || load_ok;
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign batch_valid = advance;

    // Command holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            hold_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            mode_reg    <= cmd.mode;
            channel_reg <= cmd.channel;
            freq_reg    <= cmd.tone_freq;
            len_reg     <= cmd.note_len;
            on_reg      <= cmd.music_on;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= psg_nls_pkg::NOTE_PERIOD_RST;
            level_reg  <= psg_nls_pkg::MUSIC_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psg_nls_pkg::CFG_NOTE_PERIOD: period_reg <= cfg_wdata;
                psg_nls_pkg::CFG_MUSIC_LEVEL: level_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Decode: next state and write list for the held command
    always_comb
    begin
        logic [psg_nls_pkg::CNT_W-1:0]  n;
        logic [psg_nls_pkg::STEP_W+3:0] step_ext;
        logic [15:0]                    note;
        logic [7:0]                     timer_inc;

        frames_next  = frames_reg;
        enabled_next = enabled_reg;
        step_next    = step_reg;
        timer_next   = timer_reg;
        n            = '0;
        batch.writes = '0;
        step_ext     = {4'd0, step_reg};
        note         = psg_nls_pkg::melody_note(step_ext[3:0]);
        timer_inc    = timer_reg + 8'd1;

        case (mode_reg)
            psg_nls_pkg::MODE_TICK:
            begin
                // Countdowns, in channel order
                for (int i = 0; i < psg_nls_pkg::NUM_CH; i++)
                begin
                    if (frames_reg[i] != 8'd0)
                    begin
                        frames_next[i] = frames_reg[i] - 8'd1;
                        if (frames_reg[i] == 8'd1)
                        begin
                            batch.writes[n] = '{psg_nls_pkg::KIND_ATTEN, 2'(i),
                                                psg_nls_pkg::ATTEN_SILENT};
                            n = n + 1'b1;
                        end
                    end
                end
                // Background melody
                if (enabled_reg)
                begin
                    if (timer_reg == 8'd0)
                    begin
                        if (note != 16'd0)
                        begin
                            batch.writes[n] = '{psg_nls_pkg::KIND_FREQ,
                                                psg_nls_pkg::MELODY_CH, note};
                            n = n + 1'b1;
                            batch.writes[n] = '{psg_nls_pkg::KIND_ATTEN,
                                                psg_nls_pkg::MELODY_CH,
                                                {12'd0, level_reg}};
                            n = n + 1'b1;
                        end
                        else
                        begin
                            batch.writes[n] = '{psg_nls_pkg::KIND_ATTEN,
                                                psg_nls_pkg::MELODY_CH,
                                                psg_nls_pkg::ATTEN_SILENT};
                            n = n + 1'b1;
                        end
                        if (step_reg == psg_nls_pkg::STEP_W'(psg_nls_pkg::SONG_STEPS - 1))
                            step_next = '0;
                        else
                            step_next = step_reg + 1'b1;
                    end
                    timer_next = (timer_inc >= period_reg) ? 8'd0 : timer_inc;
                end
            end
            psg_nls_pkg::MODE_TONE:
            begin
                if (channel_reg <= psg_nls_pkg::LAST_TONE_CH)
                begin
                    batch.writes[0] = '{psg_nls_pkg::KIND_FREQ, channel_reg, freq_reg};
                    batch.writes[1] = '{psg_nls_pkg::KIND_ATTEN, channel_reg,
                                        psg_nls_pkg::ATTEN_LOUD};
                    n = 3'd2;
                    frames_next[channel_reg] = len_reg;
                end
            end
            psg_nls_pkg::MODE_NOISE:
            begin
                batch.writes[0] = '{psg_nls_pkg::KIND_NOISE, psg_nls_pkg::NOISE_CH,
                                    psg_nls_pkg::NOISE_WHITE};
                batch.writes[1] = '{psg_nls_pkg::KIND_ATTEN, psg_nls_pkg::NOISE_CH,
                                    psg_nls_pkg::ATTEN_LOUD};
                n = 3'd2;
                frames_next[psg_nls_pkg::NOISE_CH] = len_reg;
            end
            psg_nls_pkg::MODE_MUSIC:
            begin
                enabled_next = on_reg;
                step_next    = '0;
                timer_next   = 8'd0;
                if (!on_reg)
                begin
                    batch.writes[0] = '{psg_nls_pkg::KIND_ATTEN, psg_nls_pkg::MELODY_CH,
                                        psg_nls_pkg::ATTEN_SILENT};
                    n = 3'd1;
                end
            end
            psg_nls_pkg::MODE_ALL_OFF:
            begin
                for (int i = 0; i < psg_nls_pkg::NUM_CH; i++)
                begin
                    batch.writes[i] = '{psg_nls_pkg::KIND_ATTEN, 2'(i),
                                        psg_nls_pkg::ATTEN_SILENT};
                    frames_next[i]  = 8'd0;
                end
                n = 3'd4;
            end
            default: ;
        endcase

        batch.count = n;
    end

    // State commit when the batch is handed over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg  <= '0;
            enabled_reg <= 1'b1;
            step_reg    <= '0;
            timer_reg   <= 8'd0;
        end
        else if (advance)
        begin
            frames_reg  <= frames_next;
            enabled_reg <= enabled_next;
            step_reg    <= step_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/psg_nls_serializer.sv =====
// ----------------------------------------------------------------------------
// psg_nls_serializer: chip write output queue
// Takes a batch of up to six writes and sends them one per cycle while the
// receiver is ready, flagging the final write of each batch.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_nls_serializer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                batch_valid,
    input  wire psg_nls_pkg::batch_t batch,
    output logic                     load_ok,
    psg_nls_wr_if.source             wr
);

    logic [psg_nls_pkg::CNT_W-1:0]                count_reg;
    psg_nls_pkg::write_t [psg_nls_pkg::MAX_WRITES-1:0] list_reg;
    logic pop;

    assign pop     = wr.valid && wr.ready;
    assign load_ok = (count_reg == '0) || ((count_reg == 3'd1) && pop);

    // Head of the queue drives the port
    assign wr.valid         = (count_reg != '0);
    assign wr.last          = (count_reg == 3'd1);
    assign wr.write_kind    = list_reg[0].kind;
    assign wr.write_channel = list_reg[0].channel;
    assign wr.write_value   = list_reg[0].value;

    // Write count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (batch_valid)
        begin
            count_reg <= batch.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // Write list, shifted toward the head on each send
    always_ff @(posedge clk)
    begin
        if (batch_valid)
        begin
            list_reg <= batch.writes;
        end
        else if (pop)
        begin
            for (int i = 0; i < psg_nls_pkg::MAX_WRITES - 1; i++)
            begin
                list_reg[i] <= list_reg[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/psg_nls_top.sv =====
// ----------------------------------------------------------------------------
// psg_note_length_sequencer_top: note-length sequencer for a sound chip
// Turns tone, noise, music and frame tick commands into chip register writes.
// ----------------------------------------------------------------------------
// Each command item is held in an input register, decoded combinationally
// into a batch of up to six chip writes, and the writes leave the output port
// one per cycle while the receiver is ready, with last set on the final one.
// A tone command for channels 0 to 2 and a noise command make two writes,
// all-off four, and a frame tick up to six. The next command is taken in the
// cycle the current batch's last write is accepted, so the single output port
// sets the rate. Configuration must be written only while idle; the block
// itself does not enforce this.
`default_nettype none

module psg_note_length_sequencer_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    psg_nls_cmd_if.sink                             cmd,
    psg_nls_wr_if.source                            wr,
    input  wire logic                               cfg_we,
    input  wire logic [psg_nls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psg_nls_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic                load_ok;
    logic                batch_valid;
    psg_nls_pkg::batch_t batch;

    psg_nls_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .load_ok     (load_ok),
        .batch_valid (batch_valid),
        .batch       (batch)
    );

    psg_nls_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (batch_valid),
        .batch       (batch),
        .load_ok     (load_ok),
        .wr          (wr)
    );

endmodule

`default_nettype wire

// ===== tb/tb_psg_note_length_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_psg_note_length_sequencer_top: self-checking bench for the sequencer
// Sends tone, noise, music, all-off and frame tick commands through the
// command channel. The bench keeps its own copy of the countdowns, the melody
// position and the registers, predicts the chip writes for every accepted
// item, and checks each write that leaves the block in order.
// ----------------------------------------------------------------------------

module tb_psg_note_length_sequencer_top;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int IDLE_PCT      = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int MAX_REPORTS   = 10;

    // Modes the block must ignore
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  channel;
        logic [15:0] tone_freq;
        logic [7:0]  note_len;
        logic        music_on;
    } sound_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [15:0] value;
        logic        last;
    } chip_write_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [psg_nls_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [psg_nls_pkg::CFG_DATA_W-1:0] cfg_wdata;

    psg_nls_cmd_if cmd_bus ();
    psg_nls_wr_if  wr_bus ();

    psg_note_length_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .wr        (wr_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Shadow state of the sequencer
    logic [7:0]  frames_left [psg_nls_pkg::NUM_CH];
    logic        melody_on;
    int          melody_step;
    logic [7:0]  note_timer;
    logic [7:0]  note_period;
    logic [3:0]  music_level;
    logic [15:0] tune_table [16];

    sound_cmd_t  pending_cmds [$];
    chip_write_t expected_writes [$];
    chip_write_t batch_q [$];

    sound_cmd_t  live_cmd;
    logic        offer;
    chip_write_t got;
    int          error_count = 0;
    int          cycle_count = 0;
    logic        quiet = 1'b0;
    logic        hold_arm = 1'b0;
    logic        hold_off = 1'b0;

    function automatic void push_write(logic [1:0] kind, logic [1:0] ch, logic [15:0] value);
        chip_write_t w;
        w.kind    = kind;
        w.channel = ch;
        w.value   = value;
        w.last    = 1'b0;
        batch_q.push_back(w);
    endfunction

    // Work out the chip writes caused by one accepted command
    task automatic predict_writes(input sound_cmd_t c);
        logic [15:0] note;
        batch_q.delete();
        case (c.mode)
            psg_nls_pkg::MODE_TICK:
            begin
                for (int i = 0; i < psg_nls_pkg::NUM_CH; i++)
                begin
                    if (frames_left[i] != 8'd0)
                    begin
                        frames_left[i] = frames_left[i] - 8'd1;
                        if (frames_left[i] == 8'd0)
                            push_write(psg_nls_pkg::KIND_ATTEN, 2'(i),
                                       psg_nls_pkg::ATTEN_SILENT);
                    end
                end
                if (melody_on)
                begin
                    if (note_timer == 8'd0)
                    begin
                        note = tune_table[melody_step % 16];
                        if (note != 16'd0)
                        begin
                            push_write(psg_nls_pkg::KIND_FREQ, psg_nls_pkg::MELODY_CH, note);
                            push_write(psg_nls_pkg::KIND_ATTEN, psg_nls_pkg::MELODY_CH,
                                       {12'd0, music_level});
                        end
                        else
                            push_write(psg_nls_pkg::KIND_ATTEN, psg_nls_pkg::MELODY_CH,
                                       psg_nls_pkg::ATTEN_SILENT);
                        melody_step = (melody_step + 1) % psg_nls_pkg::SONG_STEPS;
                    end
                    note_timer = note_timer + 8'd1;
                    // a zero period wraps every tick, like a period of one
                    if (note_timer >= note_period)
                        note_timer = 8'd0;
                end
            end
            psg_nls_pkg::MODE_TONE:
            begin
                if (c.channel <= psg_nls_pkg::LAST_TONE_CH)
                begin
                    push_write(psg_nls_pkg::KIND_FREQ, c.channel, c.tone_freq);
                    push_write(psg_nls_pkg::KIND_ATTEN, c.channel, psg_nls_pkg::ATTEN_LOUD);
                    frames_left[c.channel] = c.note_len;
                end
            end
            psg_nls_pkg::MODE_NOISE:
            begin
                push_write(psg_nls_pkg::KIND_NOISE, psg_nls_pkg::NOISE_CH,
                           psg_nls_pkg::NOISE_WHITE);
                push_write(psg_nls_pkg::KIND_ATTEN, psg_nls_pkg::NOISE_CH,
                           psg_nls_pkg::ATTEN_LOUD);
                frames_left[psg_nls_pkg::NOISE_CH] = c.note_len;
            end
            psg_nls_pkg::MODE_MUSIC:
            begin
                melody_on   = c.music_on;
                melody_step = 0;
                note_timer  = 8'd0;
                if (!c.music_on)
                    push_write(psg_nls_pkg::KIND_ATTEN, psg_nls_pkg::MELODY_CH,
                               psg_nls_pkg::ATTEN_SILENT);
            end
            psg_nls_pkg::MODE_ALL_OFF:
            begin
                for (int i = 0; i < psg_nls_pkg::NUM_CH; i++)
                begin
                    push_write(psg_nls_pkg::KIND_ATTEN, 2'(i), psg_nls_pkg::ATTEN_SILENT);
                    frames_left[i] = 8'd0;
                end
            end
            default: ;
        endcase
        if (batch_q.size() > 0)
            batch_q[batch_q.size() - 1].last = 1'b1;
        foreach (batch_q[k])
            expected_writes.push_back(batch_q[k]);
    endtask

    function automatic sound_cmd_t mk_cmd(logic [2:0] mode, logic [1:0] ch, logic [15:0] freq,
                                          logic [7:0] len, logic on);
        sound_cmd_t c;
        c.mode      = mode;
        c.channel   = ch;
        c.tone_freq = freq;
        c.note_len  = len;
        c.music_on  = on;
        return c;
    endfunction

    // Random command, weighted toward ticks and short note lengths
    function automatic sound_cmd_t random_cmd();
        sound_cmd_t c;
        int pick;
        pick        = $urandom_range(0, 99);
        c.channel   = 2'($urandom_range(0, 3));
        c.tone_freq = 16'($urandom());
        c.note_len  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 6))
                                                  : 8'($urandom_range(0, 255));
        c.music_on  = ($urandom_range(0, 3) != 0);
        if (pick < 40)
            c.mode = psg_nls_pkg::MODE_TICK;
        else if (pick < 62)
            c.mode = psg_nls_pkg::MODE_TONE;
        else if (pick < 72)
            c.mode = psg_nls_pkg::MODE_NOISE;
        else if (pick < 80)
            c.mode = psg_nls_pkg::MODE_MUSIC;
        else if (pick < 86)
            c.mode = psg_nls_pkg::MODE_ALL_OFF;
        else if (pick < 91)
            c.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else
            c.mode = psg_nls_pkg::MODE_TICK;
        return c;
    endfunction

    // Wait until every item is taken and every write has come out
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [psg_nls_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psg_nls_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == psg_nls_pkg::CFG_NOTE_PERIOD)
            note_period = data;
        else
            music_level = data[3:0];
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) pending_cmds.push_back(random_cmd());
        wait_idle();
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid     <= 1'b0;
            cmd_bus.mode      <= psg_nls_pkg::MODE_TICK;
            cmd_bus.channel   <= 2'd0;
            cmd_bus.tone_freq <= 16'd0;
            cmd_bus.note_len  <= 8'd0;
            cmd_bus.music_on  <= 1'b0;
        end
        else
        begin
            offer = cmd_bus.valid;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                predict_writes(live_cmd);
                offer = 1'b0;
            end
            if (!offer && pending_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                live_cmd = pending_cmds.pop_front();
                cmd_bus.mode      <= live_cmd.mode;
                cmd_bus.channel   <= live_cmd.channel;
                cmd_bus.tone_freq <= live_cmd.tone_freq;
                cmd_bus.note_len  <= live_cmd.note_len;
                cmd_bus.music_on  <= live_cmd.music_on;
                offer = 1'b1;
            end
            cmd_bus.valid <= offer;
        end
    end

    // Write receiver: random stalls, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            wr_bus.ready <= 1'b0;
        else
            wr_bus.ready <= !hold_off && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Write checker
    always @(posedge clk)
    begin
        if (rst_n && wr_bus.valid && wr_bus.ready)
        begin
            got.kind    = wr_bus.write_kind;
            got.channel = wr_bus.write_channel;
            got.value   = wr_bus.write_value;
            got.last    = wr_bus.last;
            if (expected_writes.size() == 0)
                flag_error($sformatf("unexpected write: kind %0d ch %0d value %0d last %0d",
                                     got.kind, got.channel, got.value, got.last));
            else if (got != expected_writes[0])
            begin
                flag_error($sformatf({"write mismatch: expected kind %0d ch %0d value %0d",
                                      " last %0d, got kind %0d ch %0d value %0d last %0d"},
                                     expected_writes[0].kind, expected_writes[0].channel,
                                     expected_writes[0].value, expected_writes[0].last,
                                     got.kind, got.channel, got.value, got.last));
                void'(expected_writes.pop_front());
            end
            else
                void'(expected_writes.pop_front());
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** psg_note_length_sequencer_top: FAILED **");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = psg_nls_pkg::CFG_NOTE_PERIOD;
        cfg_wdata = '0;
        tune_table = '{16'd262, 16'd330, 16'd392, 16'd523, 16'd392, 16'd330, 16'd262, 16'd0,
                       16'd220, 16'd262, 16'd330, 16'd440, 16'd330, 16'd262, 16'd220, 16'd0};
        foreach (frames_left[i])
            frames_left[i] = 8'd0;
        melody_on   = 1'b1;
        melody_step = 0;
        note_timer  = 8'd0;
        note_period = psg_nls_pkg::NOTE_PERIOD_RST;
        music_level = psg_nls_pkg::MUSIC_LEVEL_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: first melody note from reset, field extremes, ignored commands
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TICK, 2'd0, 16'd0, 8'd0, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd0, 16'h0000, 8'd1, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd1, 16'hFFFF, 8'd255, 1'b1));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd2, 16'h5A5A, 8'd0, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd3, 16'hFFFF, 8'd3, 1'b1));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_NOISE, 2'd3, 16'hA5A5, 8'd2, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TICK, 2'd0, 16'd0, 8'd0, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TICK, 2'd3, 16'hFFFF, 8'd255, 1'b1));
        pending_cmds.push_back(mk_cmd(MODE_UNUSED_LO, 2'd1, 16'h1234, 8'd9, 1'b1));
        pending_cmds.push_back(mk_cmd(MODE_UNUSED_HI, 2'd2, 16'hFFFF, 8'd255, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_MUSIC, 2'd0, 16'd0, 8'd0, 1'b0));
        // melody off and no countdown ending: a tick with no writes
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TICK, 2'd0, 16'd0, 8'd0, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_MUSIC, 2'd0, 16'd0, 8'd0, 1'b1));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_ALL_OFF, 2'd0, 16'd0, 8'd0, 1'b0));
        // all four countdowns end on the same tick as a melody note: six writes
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd0, 16'd100, 8'd1, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd1, 16'd200, 8'd1, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd2, 16'd300, 8'd1, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_NOISE, 2'd0, 16'd0, 8'd1, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_MUSIC, 2'd0, 16'd0, 8'd0, 1'b1));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TICK, 2'd0, 16'd0, 8'd0, 1'b0));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_TONE, 2'd2, 16'hAAAA, 8'd255, 1'b1));
        pending_cmds.push_back(mk_cmd(psg_nls_pkg::MODE_ALL_OFF, 2'd3, 16'hFFFF, 8'd255, 1'b1));
        wait_idle();

        // Reset settings
        run_random(40);

        // Fastest melody, loudest level, no stalls on either side
        write_reg(psg_nls_pkg::CFG_NOTE_PERIOD, 8'd1);
        write_reg(psg_nls_pkg::CFG_MUSIC_LEVEL, 8'd0);
        quiet = 1'b1;
        run_random(45);
        quiet = 1'b0;

        // Slowest melody, silent level, receiver backs up the block
        write_reg(psg_nls_pkg::CFG_NOTE_PERIOD, 8'd255);
        write_reg(psg_nls_pkg::CFG_MUSIC_LEVEL, 8'd15);
        hold_arm = 1'b1;
        run_random(45);

        // Period lowered while the timer is past it
        write_reg(psg_nls_pkg::CFG_NOTE_PERIOD, 8'd3);
        write_reg(psg_nls_pkg::CFG_MUSIC_LEVEL,
                  {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))});
        run_random(45);

        // Zero period behaves as one
        write_reg(psg_nls_pkg::CFG_NOTE_PERIOD, 8'd0);
        write_reg(psg_nls_pkg::CFG_MUSIC_LEVEL, {4'($urandom_range(0, 15)), 4'd7});
        run_random(45);

        write_reg(psg_nls_pkg::CFG_NOTE_PERIOD, 8'($urandom_range(1, 12)));
        write_reg(psg_nls_pkg::CFG_MUSIC_LEVEL, 8'($urandom_range(0, 15)));
        run_random(50);

        if (error_count == 0 && expected_writes.size() == 0)
            $display("** psg_note_length_sequencer_top: PASSED **");
        else
            $display("** psg_note_length_sequencer_top: FAILED **");
        $finish;
    end

endmodule
